FILE: hw/rtl/caxit_pkg.sv
// ----------------------------------------------------------------------------
// caxit_pkg
// Types, constants and register codes for the convolution axis index map.
// ----------------------------------------------------------------------------
package caxit_pkg;

  // Width of index and range fields on the item channels
  localparam int INDEX_BITS = 25;
  // Internal datapath width: holds any field value or derived axis size plus one
  localparam int WW         = ((INDEX_BITS > 25) ? INDEX_BITS : 25) + 1;

  // Divider: dividend width follows from the 16-bit sizes and 8-bit dilation
  localparam int DIV_W      = 25;
  localparam int DIV_DB     = 5;                  // quotient bits per stage
  localparam int DIV_STG    = DIV_W / DIV_DB;
  // input capture, two prep stages, divider, two result stages
  localparam int NSTG       = DIV_STG + 5;

  localparam int CFG_AW     = 5;
  localparam int CFG_DW     = 32;

  typedef enum logic [1:0] {
    OP_FWD_INDEX = 2'd0,
    OP_REV_INDEX = 2'd1,
    OP_FWD_RANGE = 2'd2,
    OP_REV_RANGE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    REG_AXIS_SIZE  = 3'd0,
    REG_TRUNC_LOW  = 3'd1,
    REG_TRUNC_HIGH = 3'd2,
    REG_DILATION   = 3'd3,
    REG_PAD_LOW    = 3'd4,
    REG_PAD_HIGH   = 3'd5,
    REG_FLIP_AXIS  = 3'd6
  } reg_e;

  typedef struct packed {
    logic [1:0]            operation;
    logic [INDEX_BITS-1:0] position;
    logic [INDEX_BITS-1:0] range_end;
    logic                  range_exact;
    logic                  range_dilated;
  } in_t;

  typedef struct packed {
    logic                  valid_res;
    logic [INDEX_BITS-1:0] mapped_begin;
    logic [INDEX_BITS-1:0] mapped_end;
    logic                  mapped_exact;
    logic                  mapped_dilated;
  } out_t;

  typedef struct packed {
    logic [15:0] axis_size;
    logic [15:0] trunc_low;
    logic [15:0] trunc_high;
    logic [7:0]  dilation;
    logic [15:0] pad_low;
    logic [15:0] pad_high;
    logic        flip_axis;
  } cfg_t;

  // Sizes derived from the configuration
  typedef struct packed {
    logic [7:0]       d;        // dilation, zero read as one
    logic [15:0]      ub;       // end of the kept part on the input axis
    logic [DIV_W-1:0] psize;    // padded axis size
    logic [DIV_W-1:0] pend;     // pad_low plus dilated size
    logic [15:0]      c0;       // begin of the image of the axis
    logic [DIV_W-1:0] cod_end;  // end of the image of the axis
  } drv_t;

  typedef struct packed {
    logic [WW-1:0] b;
    logic [WW-1:0] e;
    logic          ex;
    logic          dl;
  } sp_t;

  typedef struct packed {
    op_e              op;
    logic             ok;
    logic             emp;
    logic [WW-1:0]    b;
    logic [WW-1:0]    e;
    logic             ex;
    logic             dl;
    logic [WW-1:0]    a;
    logic [WW-1:0]    c;
    logic [DIV_W-1:0] num0;
    logic [DIV_W-1:0] num1;
    logic [DIV_W-1:0] q0;
    logic [DIV_W-1:0] q1;
    logic [7:0]       rem0;
    logic [7:0]       rem1;
  } stg_t;

endpackage

FILE: hw/rtl/conv_axis_index_transform_top.sv
// ----------------------------------------------------------------------------
// conv_axis_index_transform_top
// Pipelined truncate / dilate / pad / flip index and range map for one axis.
// ----------------------------------------------------------------------------
//  channel  | signals                              | transaction
//  ---------+--------------------------------------+---------------------------
//  in       | in_valid_i, in_ready_o, in_data_i    | one index or range request
//  out      | out_valid_o, out_ready_i, out_data_o | one mapped result
//  cfg      | psel, penable, pwrite, paddr, pwdata | one register write or read
//
//  One transaction per cycle in, one out, unless out_ready_i stalls the pipeline;
//  the reverse operations use the five-stage radix-32 divider.
//  Each stage advances when it is empty or the stage after it advances, so
//  bubbles collapse and input is taken while a finished result waits.
//  Reset clears the valid bits and sets the registers to their reset values.
//  Derived axis sizes are registered and follow a register write in the next cycle.
// ----------------------------------------------------------------------------
module conv_axis_index_transform_top
  import caxit_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_t               in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_t              out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  cfg_t             cfg_q;
  drv_t             drv_d, drv_q;
  stg_t             s_q   [NSTG];
  stg_t             nxt_d [NSTG];
  logic [NSTG-1:0]  v_q;
  logic [NSTG-1:0]  adv;
  reg_e             ridx;
  logic [16:0]      tsum;
  logic [15:0]      kept;
  logic [DIV_W-1:0] dsize;

  // --------------------------------------------------------------------------
  // span helpers

  function automatic sp_t canon_f(sp_t r);
    sp_t o;
    o = r;
    if (r.b >= r.e) begin
      o.b  = '0;
      o.e  = '0;
      o.ex = 1'b1;
      o.dl = 1'b0;
    end else if ((r.e - r.b) < WW'(3)) begin
      o.dl = 1'b0;
    end
    return o;
  endfunction

  function automatic sp_t raise_f(sp_t r, logic [WW-1:0] bound);
    sp_t o;
    o = r;
    if (bound > r.b) begin
      o.b = bound;
      if (r.dl) o.ex = 1'b0;
      o = canon_f(o);
    end
    return o;
  endfunction

  function automatic sp_t lower_f(sp_t r, logic [WW-1:0] bound);
    sp_t o;
    o = r;
    if (bound < r.e) begin
      o.e = bound;
      if (r.dl) o.ex = 1'b0;
      o = canon_f(o);
    end
    return o;
  endfunction

  function automatic logic fits_f(logic [WW-1:0] val);
    return ~|val[WW-1:INDEX_BITS];
  endfunction

  // --------------------------------------------------------------------------
  // stage functions

  // canonical range, bounds checks, clipping
  function automatic stg_t f1(stg_t x, cfg_t c, drv_t dv);
    stg_t          o;
    sp_t           r;
    logic [WW-1:0] v;
    logic [WW-1:0] t;
    o      = x;
    o.num0 = '0;
    o.num1 = '0;
    o.q0   = '0;
    o.q1   = '0;
    o.rem0 = '0;
    o.rem1 = '0;
    o.a    = '0;
    o.c    = '0;
    r.b    = x.b;
    r.e    = x.e;
    r.ex   = x.ex;
    r.dl   = x.dl;
    r      = canon_f(r);
    case (x.op)
      OP_FWD_INDEX: begin
        o.ok = (x.b < WW'(c.axis_size)) && (x.b >= WW'(c.trunc_low)) &&
               (x.b < WW'(dv.ub));
        o.a  = x.b - WW'(c.trunc_low);
      end
      OP_REV_INDEX: begin
        v      = c.flip_axis ? (WW'(dv.psize) - WW'(1) - x.b) : x.b;
        o.ok   = (x.b < WW'(dv.psize)) && (v >= WW'(c.pad_low)) &&
                 (v < WW'(dv.pend));
        t      = v - WW'(c.pad_low);
        o.num0 = o.ok ? t[DIV_W-1:0] : '0;
      end
      OP_FWD_RANGE: begin
        o.ok = !((r.b != r.e) && (r.e > WW'(c.axis_size)));
        r    = raise_f(r, WW'(c.trunc_low));
        r    = lower_f(r, WW'(dv.ub));
      end
      default: begin
        // reverse range: clip to the image of the axis
        o.ok = 1'b1;
        r    = raise_f(r, WW'(dv.c0));
        r    = lower_f(r, WW'(dv.cod_end));
      end
    endcase
    o.b   = r.b;
    o.e   = r.e;
    o.ex  = r.ex;
    o.dl  = r.dl;
    o.emp = (r.b == r.e);
    return o;
  endfunction

  // dilation products, divider operands
  function automatic stg_t f2(stg_t x, cfg_t c, drv_t dv);
    stg_t          o;
    logic [WW-1:0] w0;
    logic [WW-1:0] w1;
    logic [23:0]   p0;
    logic [23:0]   p1;
    o  = x;
    w0 = (x.op == OP_FWD_INDEX) ? x.a : (x.b - WW'(c.trunc_low));
    w1 = x.e - WW'(1) - WW'(c.trunc_low);
    p0 = 24'(w0[15:0]) * 24'(dv.d);
    p1 = 24'(w1[15:0]) * 24'(dv.d);
    case (x.op)
      OP_FWD_INDEX: o.a = WW'(p0);
      OP_REV_INDEX: o.a = '0;
      OP_FWD_RANGE: begin
        o.a = WW'(p0);
        o.c = WW'(p1);
      end
      default: begin
        if (!x.emp) begin
          // ceiling for the aligned begin, floor for the last tap
          w0     = x.b - WW'(dv.c0) + WW'(dv.d) - WW'(1);
          w1     = x.e - WW'(1) - WW'(dv.c0);
          o.num0 = w0[DIV_W-1:0];
          o.num1 = w1[DIV_W-1:0];
        end
      end
    endcase
    return o;
  endfunction

  // DIV_DB restoring steps on both dividends
  function automatic stg_t fdiv(stg_t x, logic [7:0] d);
    stg_t       o;
    logic [8:0] t0;
    logic [8:0] t1;
    o = x;
    for (int k = 0; k < DIV_DB; k++) begin
      t0     = {o.rem0, o.num0[DIV_W-1]};
      t1     = {o.rem1, o.num1[DIV_W-1]};
      o.num0 = o.num0 << 1;
      o.num1 = o.num1 << 1;
      if (t0 >= {1'b0, d}) begin
        o.rem0 = 8'(t0 - {1'b0, d});
        o.q0   = {o.q0[DIV_W-2:0], 1'b1};
      end else begin
        o.rem0 = t0[7:0];
        o.q0   = {o.q0[DIV_W-2:0], 1'b0};
      end
      if (t1 >= {1'b0, d}) begin
        o.rem1 = 8'(t1 - {1'b0, d});
        o.q1   = {o.q1[DIV_W-2:0], 1'b1};
      end else begin
        o.rem1 = t1[7:0];
        o.q1   = {o.q1[DIV_W-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  // offsets, reverse-range grid alignment
  function automatic stg_t fa(stg_t x, cfg_t c, drv_t dv);
    stg_t          o;
    sp_t           r;
    logic [WW-1:0] gb;
    o    = x;
    r.b  = x.b;
    r.e  = x.e;
    r.ex = x.ex;
    r.dl = x.dl;
    gb   = WW'(8'(dv.d - 8'd1 - x.rem0));
    case (x.op)
      OP_FWD_INDEX: o.a = x.a + WW'(c.pad_low);
      OP_REV_INDEX: begin
        o.ok = x.ok && (x.rem0 == 8'd0);
        o.a  = WW'(x.q0) + WW'(c.trunc_low);
      end
      OP_FWD_RANGE: begin
        o.a = x.a + WW'(c.pad_low);
        o.c = x.c + WW'(c.pad_low);
      end
      default: begin
        if (!x.emp) begin
          // begin moves up by the ceiling slack, end down by the floor remainder
          r     = raise_f(r, x.b + gb);
          r     = lower_f(r, x.e - WW'(x.rem1));
          o.b   = r.b;
          o.e   = r.e;
          o.ex  = r.ex;
          o.dl  = r.dl;
          o.emp = (r.b == r.e);
          o.a   = WW'(x.q0);
          o.c   = WW'(x.q1);
        end
      end
    endcase
    return o;
  endfunction

  // flip, final canonical form, width check
  function automatic stg_t fb(stg_t x, cfg_t c, drv_t dv);
    stg_t          o;
    logic [WW-1:0] res;
    logic [WW-1:0] lo;
    logic [WW-1:0] hi;
    logic [WW-1:0] en;
    logic          dl;
    logic          good;
    o    = x;
    res  = c.flip_axis ? (WW'(dv.psize) - WW'(1) - x.a) : x.a;
    lo   = '0;
    hi   = '0;
    dl   = 1'b0;
    good = 1'b0;
    o.b  = '0;
    o.e  = '0;
    o.ex = 1'b0;
    o.dl = 1'b0;
    case (x.op)
      OP_FWD_INDEX: begin
        good = x.ok && fits_f(res);
        o.b  = good ? res : '0;
      end
      OP_REV_INDEX: begin
        good = x.ok && fits_f(x.a);
        o.b  = good ? x.a : '0;
      end
      OP_FWD_RANGE: begin
        lo = c.flip_axis ? (WW'(dv.psize) - WW'(1) - x.c) : x.a;
        hi = c.flip_axis ? (WW'(dv.psize) - WW'(1) - x.a) : x.c;
        dl = x.dl || (dv.d > 8'd1);
      end
      default: begin
        lo = c.flip_axis ? (WW'(dv.ub) - WW'(1) - x.c) : (WW'(c.trunc_low) + x.a);
        hi = c.flip_axis ? (WW'(dv.ub) - WW'(1) - x.a) : (WW'(c.trunc_low) + x.c);
        dl = x.dl;
      end
    endcase
    en = hi + WW'(1);
    if ((x.op == OP_FWD_RANGE) || (x.op == OP_REV_RANGE)) begin
      if (!x.ok) begin
        good = 1'b0;
      end else if (x.emp) begin
        good = 1'b1;
        o.ex = 1'b1;
      end else begin
        good = fits_f(lo) && fits_f(en);
        o.b  = good ? lo : '0;
        o.e  = good ? en : '0;
        o.ex = good && x.ex;
        o.dl = good && dl && ((en - lo) >= WW'(3));
      end
    end
    o.ok = good;
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // configuration registers

  assign pready = 1'b1;
  assign ridx   = reg_e'(paddr[CFG_AW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.axis_size  <= '0;
      cfg_q.trunc_low  <= '0;
      cfg_q.trunc_high <= '0;
      cfg_q.dilation   <= 8'd1;
      cfg_q.pad_low    <= '0;
      cfg_q.pad_high   <= '0;
      cfg_q.flip_axis  <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        REG_AXIS_SIZE:  cfg_q.axis_size  <= pwdata[15:0];
        REG_TRUNC_LOW:  cfg_q.trunc_low  <= pwdata[15:0];
        REG_TRUNC_HIGH: cfg_q.trunc_high <= pwdata[15:0];
        REG_DILATION:   cfg_q.dilation   <= pwdata[7:0];
        REG_PAD_LOW:    cfg_q.pad_low    <= pwdata[15:0];
        REG_PAD_HIGH:   cfg_q.pad_high   <= pwdata[15:0];
        REG_FLIP_AXIS:  cfg_q.flip_axis  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_AXIS_SIZE:  prdata = CFG_DW'(cfg_q.axis_size);
      REG_TRUNC_LOW:  prdata = CFG_DW'(cfg_q.trunc_low);
      REG_TRUNC_HIGH: prdata = CFG_DW'(cfg_q.trunc_high);
      REG_DILATION:   prdata = CFG_DW'(cfg_q.dilation);
      REG_PAD_LOW:    prdata = CFG_DW'(cfg_q.pad_low);
      REG_PAD_HIGH:   prdata = CFG_DW'(cfg_q.pad_high);
      REG_FLIP_AXIS:  prdata = CFG_DW'(cfg_q.flip_axis);
      default:        prdata = '0;
    endcase
  end

  // derived sizes, following the registers in the next cycle
  always_comb begin
    tsum          = 17'(cfg_q.trunc_low) + 17'(cfg_q.trunc_high);
    kept          = (tsum >= 17'(cfg_q.axis_size)) ? 16'd0 :
                    16'(17'(cfg_q.axis_size) - tsum);
    drv_d.d       = (cfg_q.dilation == 8'd0) ? 8'd1 : cfg_q.dilation;
    drv_d.ub      = (cfg_q.trunc_high >= cfg_q.axis_size) ? 16'd0 :
                    (cfg_q.axis_size - cfg_q.trunc_high);
    dsize         = (kept == 16'd0) ? '0 :
                    (DIV_W'(1) + DIV_W'(24'(kept - 16'd1) * 24'(drv_d.d)));
    drv_d.pend    = DIV_W'(cfg_q.pad_low) + dsize;
    drv_d.psize   = drv_d.pend + DIV_W'(cfg_q.pad_high);
    drv_d.c0      = cfg_q.flip_axis ? cfg_q.pad_high : cfg_q.pad_low;
    drv_d.cod_end = DIV_W'(drv_d.c0) + dsize;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_q.d       <= 8'd1;
      drv_q.ub      <= '0;
      drv_q.psize   <= '0;
      drv_q.pend    <= '0;
      drv_q.c0      <= '0;
      drv_q.cod_end <= '0;
    end else begin
      drv_q <= drv_d;
    end
  end

  // --------------------------------------------------------------------------
  // pipeline

  always_comb begin
    nxt_d[0]      = '0;
    nxt_d[0].op   = op_e'(in_data_i.operation);
    nxt_d[0].b    = WW'(in_data_i.position);
    nxt_d[0].e    = WW'(in_data_i.range_end);
    nxt_d[0].ex   = in_data_i.range_exact;
    nxt_d[0].dl   = in_data_i.range_dilated;
    nxt_d[1]      = f1(s_q[0], cfg_q, drv_q);
    nxt_d[2]      = f2(s_q[1], cfg_q, drv_q);
    for (int j = 0; j < DIV_STG; j++) begin
      nxt_d[3+j] = fdiv(s_q[2+j], drv_q.d);
    end
    nxt_d[NSTG-2] = fa(s_q[NSTG-3], cfg_q, drv_q);
    nxt_d[NSTG-1] = fb(s_q[NSTG-2], cfg_q, drv_q);
  end

  always_comb begin
    adv[NSTG-1] = !v_q[NSTG-1] || out_ready_i;
    for (int i = NSTG - 2; i >= 0; i--) begin
      adv[i] = !v_q[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= in_valid_i;
      for (int i = 1; i < NSTG; i++) begin
        if (adv[i]) v_q[i] <= v_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NSTG; i++) begin
      if (adv[i]) s_q[i] <= nxt_d[i];
    end
  end

  assign in_ready_o                = adv[0];
  assign out_valid_o               = v_q[NSTG-1];
  assign out_data_o.valid_res      = s_q[NSTG-1].ok;
  assign out_data_o.mapped_begin   = s_q[NSTG-1].b[INDEX_BITS-1:0];
  assign out_data_o.mapped_end     = s_q[NSTG-1].e[INDEX_BITS-1:0];
  assign out_data_o.mapped_exact   = s_q[NSTG-1].ex;
  assign out_data_o.mapped_dilated = s_q[NSTG-1].dl;

  // --------------------------------------------------------------------------
  // assertions

  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.valid_res |->
      (out_data_o.mapped_begin == '0) && (out_data_o.mapped_end == '0) &&
      !out_data_o.mapped_exact && !out_data_o.mapped_dilated)
    else $error("invalid result carries nonzero fields");

  a_index_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((s_q[NSTG-1].op == OP_FWD_INDEX) ||
                    (s_q[NSTG-1].op == OP_REV_INDEX)) |->
      (out_data_o.mapped_end == '0) && !out_data_o.mapped_exact &&
      !out_data_o.mapped_dilated)
    else $error("index result carries range fields");

  a_range_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.valid_res &&
    ((s_q[NSTG-1].op == OP_FWD_RANGE) || (s_q[NSTG-1].op == OP_REV_RANGE)) |->
      (out_data_o.mapped_begin < out_data_o.mapped_end) ||
      ((out_data_o.mapped_begin == '0) && (out_data_o.mapped_end == '0) &&
       out_data_o.mapped_exact && !out_data_o.mapped_dilated))
    else $error("range result not canonical");

  a_dilated_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.mapped_dilated |->
      ((33'(out_data_o.mapped_end) - 33'(out_data_o.mapped_begin)) >= 33'd3))
    else $error("short range flagged dilated");

  a_divisor_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    drv_q.d != 8'd0)
    else $error("divider sees zero divisor");

  a_capture : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v_q[0])
    else $error("accepted transaction not captured");

endmodule
